/* rtl/ppmd_pkg.sv */
package ppmd_pkg;

  // Default limit on the parsed width and height.
  localparam int MAX_DIM_DEF = 4096;

  // Entries in the queue between the byte classifier and the parser.
  localparam int Q_DEPTH = 4;

  localparam int DIM_OUT_W = 13;
  localparam int MAXVAL_W  = 9;

  localparam logic [7:0] CH_P    = 8'h50;
  localparam logic [7:0] CH_SIX  = 8'h36;
  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  localparam logic [MAXVAL_W-1:0] MAXVAL_OK  = 9'd255;
  localparam logic [MAXVAL_W-1:0] MAXVAL_CAP = 9'd256;
  localparam logic [7:0]          ALPHA      = 8'hFF;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_MAGIC  = 3'd1;
  localparam logic [2:0] ST_MAXVAL = 3'd2;
  localparam logic [2:0] ST_ZERO   = 3'd3;
  localparam logic [2:0] ST_LARGE  = 3'd4;
  localparam logic [2:0] ST_TRUNC  = 3'd5;

  // One input byte together with its character class.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       is_digit;
    logic [3:0] digit;
    logic       is_nl;
    logic       is_ws;
    logic       is_hash;
  } token_t;

endpackage

/* rtl/ppmd_ifs.sv */
interface ppmd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;

  modport source(output valid, output byte_value, output last_byte, input ready);
  modport sink(input valid, input byte_value, input last_byte, output ready);
endinterface

interface ppmd_out_if;
  logic        valid;
  logic        ready;
  logic        pixel_valid;
  logic [31:0] pixel_bgra;
  logic        done_res;
  logic [2:0]  status;
  logic [12:0] image_width;
  logic [12:0] image_height;

  modport source(output valid, output pixel_valid, output pixel_bgra, output done_res,
                 output status, output image_width, output image_height, input ready);
  modport sink(input valid, input pixel_valid, input pixel_bgra, input done_res,
               input status, input image_width, input image_height, output ready);
endinterface

/* rtl/ppmd_front.sv */
module ppmd_front (
  input  logic             clk,
  input  logic             rst_n,
  ppmd_in_if.sink          in_ch,
  output logic             q_valid,
  output ppmd_pkg::token_t q_tok,
  input  logic             q_pop
);

  localparam int QA_W = $clog2(ppmd_pkg::Q_DEPTH);

  ppmd_pkg::token_t       mem_r [ppmd_pkg::Q_DEPTH];
  logic [QA_W-1:0]        wr_ptr_r;
  logic [QA_W-1:0]        rd_ptr_r;
  logic [QA_W:0]          count_r;
  ppmd_pkg::token_t       tok;
  logic                   push;

  // Classify the byte on the way in so the parser only tests flags.
  always_comb begin
    tok.data     = in_ch.byte_value;
    tok.last     = in_ch.last_byte;
    tok.is_digit = (in_ch.byte_value >= ppmd_pkg::CH_ZERO) &&
                   (in_ch.byte_value <= ppmd_pkg::CH_NINE);
    tok.digit    = in_ch.byte_value[3:0];
    tok.is_nl    = in_ch.byte_value == ppmd_pkg::CH_NL;
    tok.is_ws    = (in_ch.byte_value == ppmd_pkg::CH_SP) ||
                   (in_ch.byte_value == ppmd_pkg::CH_TAB);
    tok.is_hash  = in_ch.byte_value == ppmd_pkg::CH_HASH;
  end

  assign in_ch.ready = count_r != (QA_W + 1)'(ppmd_pkg::Q_DEPTH);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = count_r != '0;
  assign q_tok       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !q_pop) begin
        count_r <= count_r + 1'b1;
      end else if (q_pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

/* rtl/ppmd_back.sv */
module ppmd_back #(
  parameter int MAX_DIM = ppmd_pkg::MAX_DIM_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  ppmd_pkg::token_t q_tok,
  output logic             q_pop,
  ppmd_out_if.source       out_ch
);

  localparam int DIM_W = $clog2(MAX_DIM + 2);
  localparam int MV_W  = ppmd_pkg::MAXVAL_W;
  localparam int OW    = ppmd_pkg::DIM_OUT_W;
  localparam logic [DIM_W-1:0] DIM_CAP = DIM_W'(MAX_DIM + 1);
  localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

  typedef enum logic [3:0] {
    PH_MAGIC_P    = 4'd0,
    PH_MAGIC_6    = 4'd1,
    PH_MAGIC_NL   = 4'd2,
    PH_LINE_START = 4'd3,
    PH_COMMENT    = 4'd4,
    PH_WIDTH      = 4'd5,
    PH_GAP        = 4'd6,
    PH_HEIGHT     = 4'd7,
    PH_DIM_TAIL   = 4'd8,
    PH_MAXVAL     = 4'd9,
    PH_MAX_TAIL   = 4'd10,
    PH_PIXELS     = 4'd11,
    PH_IDLE       = 4'd12
  } phase_t;

  phase_t           phase_r, phase_nxt, eph;
  logic [DIM_W-1:0] wacc_r, wacc_nxt;
  logic [DIM_W-1:0] hacc_r, hacc_nxt;
  logic [MV_W-1:0]  macc_r, macc_nxt;
  logic [2:0]       err_r, err_nxt;
  logic [DIM_W-1:0] col_r, col_nxt;
  logic [DIM_W-1:0] row_r, row_nxt;
  logic [1:0]       ch_r, ch_nxt;
  logic [7:0]       red_r, red_nxt;
  logic [7:0]       green_r, green_nxt;
  logic             got;
  logic [2:0]       st;
  logic             advance;
  logic [DIM_W+OW-1:0] wext, hext;

  logic             out_valid_r;
  logic             pix_valid_r;
  logic [31:0]      bgra_r;
  logic             done_r;
  logic [2:0]       status_r;
  logic [OW-1:0]    width_r;
  logic [OW-1:0]    height_r;

  function automatic logic [DIM_W-1:0] add_dim(input logic [DIM_W-1:0] acc,
                                               input logic [3:0] d);
    logic [DIM_W+3:0] sum;
    begin
      sum = {4'b0, acc} * (DIM_W + 4)'(10) + (DIM_W + 4)'(d);
      if (acc >= DIM_CAP) begin
        return DIM_CAP;
      end else if (sum > {4'b0, DIM_CAP}) begin
        return DIM_CAP;
      end
      return sum[DIM_W-1:0];
    end
  endfunction

  function automatic logic [MV_W-1:0] add_mv(input logic [MV_W-1:0] acc,
                                             input logic [3:0] d);
    logic [MV_W+3:0] sum;
    begin
      sum = {4'b0, acc} * (MV_W + 4)'(10) + (MV_W + 4)'(d);
      if (acc >= ppmd_pkg::MAXVAL_CAP) begin
        return ppmd_pkg::MAXVAL_CAP;
      end else if (sum > {4'b0, ppmd_pkg::MAXVAL_CAP}) begin
        return ppmd_pkg::MAXVAL_CAP;
      end
      return sum[MV_W-1:0];
    end
  endfunction

  function automatic logic [2:0] hdr_check(input logic [DIM_W-1:0] w,
                                           input logic [DIM_W-1:0] h,
                                           input logic [MV_W-1:0] m);
    begin
      if (m != ppmd_pkg::MAXVAL_OK) begin
        return ppmd_pkg::ST_MAXVAL;
      end else if (w == '0 || h == '0) begin
        return ppmd_pkg::ST_ZERO;
      end else if (w > DIM_MAX || h > DIM_MAX) begin
        return ppmd_pkg::ST_LARGE;
      end
      return ppmd_pkg::ST_OK;
    end
  endfunction

  assign advance = !out_valid_r || out_ch.ready;
  assign q_pop   = q_valid && advance;

  always_comb begin
    phase_nxt = phase_r;
    wacc_nxt  = wacc_r;
    hacc_nxt  = hacc_r;
    macc_nxt  = macc_r;
    err_nxt   = err_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    ch_nxt    = ch_r;
    red_nxt   = red_r;
    green_nxt = green_r;
    got       = 1'b0;
    st        = ppmd_pkg::ST_OK;

    // A byte that ends one header field is handled by the field that follows.
    eph = phase_r;
    if (eph == PH_LINE_START && !q_tok.is_hash) eph = PH_WIDTH;
    if (eph == PH_WIDTH && !q_tok.is_digit) eph = PH_GAP;
    if (eph == PH_GAP && !q_tok.is_ws) eph = PH_HEIGHT;
    if (eph == PH_HEIGHT && !q_tok.is_digit) eph = PH_DIM_TAIL;
    if (eph == PH_MAXVAL && !q_tok.is_digit) eph = PH_MAX_TAIL;
    phase_nxt = eph;

    case (eph)
      PH_MAGIC_P: begin
        if (q_tok.data == ppmd_pkg::CH_P) begin
          phase_nxt = PH_MAGIC_6;
        end else begin
          err_nxt   = ppmd_pkg::ST_MAGIC;
          phase_nxt = PH_IDLE;
        end
      end
      PH_MAGIC_6: begin
        if (q_tok.data == ppmd_pkg::CH_SIX) begin
          phase_nxt = PH_MAGIC_NL;
        end else begin
          err_nxt   = ppmd_pkg::ST_MAGIC;
          phase_nxt = PH_IDLE;
        end
      end
      PH_MAGIC_NL: begin
        if (q_tok.is_nl) begin
          phase_nxt = PH_LINE_START;
        end else begin
          err_nxt   = ppmd_pkg::ST_MAGIC;
          phase_nxt = PH_IDLE;
        end
      end
      PH_LINE_START: begin
        phase_nxt = PH_COMMENT;
      end
      PH_COMMENT: begin
        if (q_tok.is_nl) begin
          phase_nxt = PH_LINE_START;
        end
      end
      PH_WIDTH: begin
        wacc_nxt = add_dim(wacc_r, q_tok.digit);
      end
      PH_GAP: begin
        phase_nxt = PH_GAP;
      end
      PH_HEIGHT: begin
        hacc_nxt = add_dim(hacc_r, q_tok.digit);
      end
      PH_DIM_TAIL: begin
        if (q_tok.is_nl) begin
          phase_nxt = PH_MAXVAL;
        end
      end
      PH_MAXVAL: begin
        macc_nxt = add_mv(macc_r, q_tok.digit);
      end
      PH_MAX_TAIL: begin
        if (q_tok.is_nl) begin
          err_nxt   = hdr_check(wacc_r, hacc_r, macc_r);
          phase_nxt = (err_nxt != ppmd_pkg::ST_OK) ? PH_IDLE : PH_PIXELS;
        end
      end
      PH_PIXELS: begin
        if (ch_r == 2'd0) begin
          red_nxt = q_tok.data;
          ch_nxt  = 2'd1;
        end else if (ch_r == 2'd1) begin
          green_nxt = q_tok.data;
          ch_nxt    = 2'd2;
        end else begin
          ch_nxt = 2'd0;
          got    = 1'b1;
          if (col_r + 1'b1 >= wacc_r) begin
            col_nxt = '0;
            row_nxt = row_r + 1'b1;
            if (row_r + 1'b1 >= hacc_r) begin
              phase_nxt = PH_IDLE;
            end
          end else begin
            col_nxt = col_r + 1'b1;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase

    if (err_nxt != ppmd_pkg::ST_OK) begin
      st = err_nxt;
    end else if (phase_nxt <= PH_MAGIC_NL) begin
      st = ppmd_pkg::ST_MAGIC;
    end else if (phase_nxt < PH_PIXELS) begin
      st = hdr_check(wacc_nxt, hacc_nxt, macc_nxt);
      if (st == ppmd_pkg::ST_OK) begin
        st = ppmd_pkg::ST_TRUNC;
      end
    end else if (phase_nxt == PH_PIXELS) begin
      st = ppmd_pkg::ST_TRUNC;
    end
  end

  assign wext = {{OW{1'b0}}, wacc_nxt};
  assign hext = {{OW{1'b0}}, hacc_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_MAGIC_P;
      wacc_r      <= '0;
      hacc_r      <= '0;
      macc_r      <= '0;
      err_r       <= ppmd_pkg::ST_OK;
      col_r       <= '0;
      row_r       <= '0;
      ch_r        <= 2'd0;
      red_r       <= '0;
      green_r     <= '0;
      out_valid_r <= 1'b0;
      pix_valid_r <= 1'b0;
      bgra_r      <= '0;
      done_r      <= 1'b0;
      status_r    <= ppmd_pkg::ST_OK;
      width_r     <= '0;
      height_r    <= '0;
    end else begin
      if (q_pop) begin
        out_valid_r <= got || q_tok.last;
        pix_valid_r <= got;
        bgra_r      <= got ? {ppmd_pkg::ALPHA, red_r, green_r, q_tok.data} : 32'd0;
        done_r      <= q_tok.last;
        status_r    <= q_tok.last ? st : ppmd_pkg::ST_OK;
        width_r     <= q_tok.last ? wext[OW-1:0] : '0;
        height_r    <= q_tok.last ? hext[OW-1:0] : '0;
        // The end of a file puts every parse register back to its start value.
        if (q_tok.last) begin
          phase_r <= PH_MAGIC_P;
          wacc_r  <= '0;
          hacc_r  <= '0;
          macc_r  <= '0;
          err_r   <= ppmd_pkg::ST_OK;
          col_r   <= '0;
          row_r   <= '0;
          ch_r    <= 2'd0;
          red_r   <= '0;
          green_r <= '0;
        end else begin
          phase_r <= phase_nxt;
          wacc_r  <= wacc_nxt;
          hacc_r  <= hacc_nxt;
          macc_r  <= macc_nxt;
          err_r   <= err_nxt;
          col_r   <= col_nxt;
          row_r   <= row_nxt;
          ch_r    <= ch_nxt;
          red_r   <= red_nxt;
          green_r <= green_nxt;
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pixel_valid  = pix_valid_r;
  assign out_ch.pixel_bgra   = bgra_r;
  assign out_ch.done_res     = done_r;
  assign out_ch.status       = status_r;
  assign out_ch.image_width  = width_r;
  assign out_ch.image_height = height_r;

`ifndef SYNTH
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && q_tok.last |=> phase_r == PH_MAGIC_P && ch_r == 2'd0 && err_r == ppmd_pkg::ST_OK)
    else $error("parser did not restart after the last byte");

  a_pixels_clean: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PIXELS |-> err_r == ppmd_pkg::ST_OK && wacc_r != '0 && col_r < wacc_r)
    else $error("pixel phase entered with a bad header or column overrun");

  a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> pix_valid_r || done_r)
    else $error("result carries neither a pixel nor an end of file");

  a_no_pop_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !q_pop)
    else $error("queue popped while a result is stalled");
`endif

endmodule

/* rtl/ppm_p6_stream_decoder_core.sv */
// Binary PPM (P6) stream decoder: one file byte per item, one result per pixel or end of file.
// A byte accepted is written into the byte queue and popped by the parser once the output register
// is free or being taken; its result is then registered in the output register.
// Throughput: one byte per cycle while the output register is not stalled.
// A four-entry byte queue lets the input run on while the output register is stalled.
// Reset (rst_n low, synchronous) empties the queue and the output and restarts at the magic.
module ppm_p6_stream_decoder_core #(
  parameter int MAX_DIM = ppmd_pkg::MAX_DIM_DEF
) (
  input logic        clk,
  input logic        rst_n,
  ppmd_in_if.sink    in_ch,
  ppmd_out_if.source out_ch
);

  logic             q_valid;
  logic             q_pop;
  ppmd_pkg::token_t q_tok;

  ppmd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_tok   (q_tok),
    .q_pop   (q_pop)
  );

  ppmd_back #(
    .MAX_DIM (MAX_DIM)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_tok   (q_tok),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
